[hdl/lspb_pkg.sv]
// Shared constants and types for the trapezoidal profile sampler.
package lspb_pkg;

    // Fixed-point formats: times are Q.8, positions and rates are Q.16.
    localparam int TIME_FRAC = 8;
    localparam int POS_FRAC  = 16;

    // Cruise velocity is 1.5 * d / tf; with the formats above that is 384 * d / tf.
    localparam int VEL_SCALE = 3 << (TIME_FRAC - 1);
    // Blend acceleration is 4.5 * d / tf^2; in raw units 294912 * d / tf^2.
    localparam int ACC_SCALE = 9 << (POS_FRAC - 1);

    localparam int CFG_W = 2;
    localparam logic [CFG_W-1:0] CFG_START_POSITION = 2'd0;
    localparam logic [CFG_W-1:0] CFG_END_POSITION   = 2'd1;
    localparam logic [CFG_W-1:0] CFG_FINAL_TIME     = 2'd2;

    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PHASE_ACCEL  = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CRUISE = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_DECEL  = 2'd2;

    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_TIME_ZERO = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_SAME_ENDS = 2'd2;

    typedef enum logic [1:0] {
        DRV_IDLE,
        DRV_VEL,
        DRV_ACC
    } t_drv_state;

endpackage

[hdl/lspb_trajectory_sampler.sv]
// Top level of the linear-segment, parabolic-blend (trapezoidal) profile sampler.
// Throughput: one request per cycle through six register stages with per-stage stalls.
// After reset or a register write two divisions of NUM_BITS bits rederive the profile and
// requests wait until both are done (NUM_BITS = max(POSITION_BITS + 20, 2 * TIME_BITS) + 1).
// Reset is synchronous, active low, and clears registers, derived values and valid bits.
module lspb_trajectory_sampler #(
    parameter int POSITION_BITS = 32,
    parameter int TIME_BITS     = 24
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lspb_pkg::CFG_W-1:0]       i_cfg_index,
    input  logic [((POSITION_BITS > TIME_BITS) ? POSITION_BITS : TIME_BITS)-1:0] i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [TIME_BITS-1:0]             i_sample_time,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [POSITION_BITS-1:0]  o_position,
    output logic signed [POSITION_BITS-1:0]  o_velocity,
    output logic signed [POSITION_BITS-1:0]  o_acceleration,
    output logic [lspb_pkg::PHASE_W-1:0]     o_phase,
    output logic [lspb_pkg::STATUS_W-1:0]    o_status
);
    import lspb_pkg::*;

    localparam int PB = POSITION_BITS;
    localparam int TB = TIME_BITS;
    // Divisor width covers tf^2; numerator width covers 294912 * |d| plus half the divisor.
    localparam int DB = 2 * TB;
    localparam int NW = (((PB + 20) > DB) ? (PB + 20) : DB) + 1;
    // Working width for products and rounding in the sample pipeline.
    localparam int WW = PB + TB + 4;
    localparam int MW = PB + TB + 2;
    // ceil(2^(TB+2) / 3): multiplying by it and shifting right by TB + 2 divides any
    // value up to 2^TB exactly by three.
    localparam longint TB_RECIP_L = ((longint'(1) <<< (TB + 2)) + longint'(2)) / longint'(3);
    localparam logic [TB:0] TB_RECIP = (TB+1)'(TB_RECIP_L);

    // Round to nearest with ties away from zero, dividing by 2^k.
    function automatic logic signed [WW-1:0] rnd_shift(input logic signed [WW-1:0] x,
                                                      input int unsigned k);
        logic [WW-1:0] mag;
        logic [WW-1:0] q;
        mag = x[WW-1] ? $unsigned(-x) : $unsigned(x);
        q   = (mag + (WW'(1) << (k - 1))) >> k;
        return x[WW-1] ? -$signed(q) : $signed(q);
    endfunction

    function automatic logic signed [PB-1:0] sat_pos(input logic signed [WW-1:0] x);
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        hi = $signed((WW'(1) << (PB - 1)) - WW'(1));
        lo = -hi - WW'(1);
        if (x > hi) begin
            return hi[PB-1:0];
        end else if (x < lo) begin
            return lo[PB-1:0];
        end
        return x[PB-1:0];
    endfunction

    // Apply the sign to a divider quotient and saturate it.
    function automatic logic signed [PB-1:0] sat_quo(input logic [NW-1:0] q, input logic neg);
        logic [NW-1:0] lim;
        lim = NW'(1) << (PB - 1);
        if (neg) begin
            return (q > lim) ? {1'b1, {(PB-1){1'b0}}} : PB'(~q + NW'(1));
        end
        return (q >= lim) ? {1'b0, {(PB-1){1'b1}}} : q[PB-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and derived profile values.
    // ------------------------------------------------------------------
    logic signed [PB-1:0] r_start;
    logic signed [PB-1:0] r_end;
    logic [TB-1:0]        r_tf;
    logic signed [PB-1:0] r_vel;
    logic signed [PB-1:0] r_acc;
    logic [TB-1:0]        r_tb;
    logic                 r_drv_ok;

    t_drv_state r_state;
    t_drv_state n_state;

    logic signed [PB:0] pos_delta;
    logic               dneg;
    logic [PB:0]        dmag;
    logic [DB-1:0]      tf_sq;
    logic [2*TB+1:0]    tb_prod;
    logic [TB-1:0]      tb_calc;

    logic               div_start;
    logic [NW-1:0]      div_num;
    logic [DB-1:0]      div_den;
    logic               div_done;
    logic [NW-1:0]      div_quo;

    // The blend time is round(tf / 3), which equals floor((tf + 1) / 3).
    always_comb begin
        pos_delta = $signed({r_end[PB-1], r_end}) - $signed({r_start[PB-1], r_start});
        dneg      = pos_delta[PB];
        dmag      = dneg ? $unsigned(-pos_delta) : $unsigned(pos_delta);
        tf_sq     = DB'(r_tf) * DB'(r_tf);
        tb_prod   = (2*TB+2)'({1'b0, r_tf} + (TB+1)'(1)) * (2*TB+2)'(TB_RECIP);
        tb_calc   = tb_prod[2*TB+1:TB+2];
    end

    // The derivation runs two divisions in turn: cruise velocity, then blend
    // acceleration. The blend time comes from a reciprocal multiply alongside.
    // A register write restarts it.
    always_comb begin
        n_state = r_state;
        case (r_state)
            DRV_IDLE:  if (!r_drv_ok) n_state = DRV_VEL;
            DRV_VEL:   if (div_done)  n_state = DRV_ACC;
            DRV_ACC:   if (div_done)  n_state = DRV_IDLE;
            default:   n_state = DRV_IDLE;
        endcase
        if (i_cfg_we) begin
            n_state = DRV_IDLE;
        end
    end

    // Each division rounds by adding half the divisor to the magnitude first.
    always_comb begin
        div_start = 1'b0;
        div_num   = NW'(dmag) * NW'(VEL_SCALE) + NW'(r_tf >> 1);
        div_den   = DB'(r_tf);
        case (r_state)
            DRV_IDLE: begin
                div_start = !r_drv_ok;
            end
            DRV_VEL: begin
                div_start = div_done;
                div_num   = NW'(dmag) * NW'(ACC_SCALE) + NW'(tf_sq >> 1);
                div_den   = tf_sq;
            end
            DRV_ACC: begin
                div_start = 1'b0;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
        if (i_cfg_we) begin
            div_start = 1'b0;
        end
    end

    lspb_div #(
        .NUM_BITS (NW),
        .DEN_BITS (DB)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= DRV_IDLE;
            r_start  <= '0;
            r_end    <= '0;
            r_tf     <= '0;
            r_vel    <= '0;
            r_acc    <= '0;
            r_tb     <= '0;
            r_drv_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_START_POSITION: begin
                        r_start  <= i_cfg_data[PB-1:0];
                        r_drv_ok <= 1'b0;
                    end
                    CFG_END_POSITION: begin
                        r_end    <= i_cfg_data[PB-1:0];
                        r_drv_ok <= 1'b0;
                    end
                    CFG_FINAL_TIME: begin
                        r_tf     <= i_cfg_data[TB-1:0];
                        r_drv_ok <= 1'b0;
                    end
                    default: begin
                    end
                endcase
            end else if (div_done) begin
                case (r_state)
                    DRV_VEL: r_vel <= sat_quo(div_quo, dneg);
                    DRV_ACC: begin
                        r_acc    <= sat_quo(div_quo, dneg);
                        r_tb     <= tb_calc;
                        r_drv_ok <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample pipeline. Each stage advances when it is empty or the next one
    // advances, so bubbles close up and a stall drops nothing.
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5, r_v6;
    logic en1, en2, en3, en4, en5, en6;

    assign en6     = !r_v6 || i_ready;
    assign en5     = !r_v5 || en6;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1 && r_drv_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_v6 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid && o_ready;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
            if (en6) r_v6 <= r_v5;
        end
    end

    // Stage 1: samples past the final time are held at the final time.
    logic [TB-1:0] r1_t;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_t <= (i_sample_time > r_tf) ? r_tf : i_sample_time;
        end
    end

    // Stage 2: pick the segment and the time operand for it.
    logic [TB-1:0]          cruise_end;
    logic [TB-1:0]          time_left;
    logic signed [TB+1:0]   cruise_ofs;
    logic [PHASE_W-1:0]     phase_s2;
    logic signed [TB+1:0]   u_s2;
    logic [TB-1:0]          w_s2;
    logic [PHASE_W-1:0]     r2_phase;
    logic signed [TB+1:0]   r2_u;
    logic [TB-1:0]          r2_w;

    always_comb begin
        cruise_end = r_tf - r_tb;
        time_left  = r_tf - r1_t;
        cruise_ofs = $signed({1'b0, r1_t, 1'b0}) - $signed({2'b00, r_tf});
        if (r1_t <= r_tb) begin
            phase_s2 = PHASE_ACCEL;
            u_s2     = $signed({2'b00, r1_t});
            w_s2     = r1_t;
        end else if (r1_t <= cruise_end) begin
            phase_s2 = PHASE_CRUISE;
            u_s2     = cruise_ofs;
            w_s2     = r1_t;
        end else begin
            phase_s2 = PHASE_DECEL;
            u_s2     = $signed({2'b00, time_left});
            w_s2     = time_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r2_phase <= phase_s2;
            r2_u     <= u_s2;
            r2_w     <= w_s2;
        end
    end

    // Stage 3: one multiply, acceleration times time in the blends and
    // cruise velocity times twice the centered time offset in cruise.
    logic signed [PB-1:0]   coef_s3;
    logic signed [MW-1:0]   r3_m;
    logic [PHASE_W-1:0]     r3_phase;
    logic [TB-1:0]          r3_w;

    assign coef_s3 = (r2_phase == PHASE_CRUISE) ? r_vel : r_acc;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_m     <= coef_s3 * r2_u;
            r3_phase <= r2_phase;
            r3_w     <= r2_w;
        end
    end

    // Stage 4: blend velocity, or the whole cruise position.
    logic signed [WW-1:0]   m_s4;
    logic signed [WW-1:0]   cruise_sum;
    logic signed [PB-1:0]   vel_s4;
    logic signed [PB-1:0]   pos_s4;
    logic signed [PB-1:0]   r4_vel;
    logic signed [PB-1:0]   r4_pos;
    logic [PHASE_W-1:0]     r4_phase;
    logic [TB-1:0]          r4_w;

    always_comb begin
        m_s4       = WW'(r3_m);
        cruise_sum = ((WW'(r_start) + WW'(r_end)) <<< TIME_FRAC) + m_s4;
        pos_s4     = sat_pos(rnd_shift(cruise_sum, TIME_FRAC + 1));
        vel_s4     = (r3_phase == PHASE_CRUISE) ? r_vel : sat_pos(rnd_shift(m_s4, TIME_FRAC));
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_vel   <= vel_s4;
            r4_pos   <= pos_s4;
            r4_phase <= r3_phase;
            r4_w     <= r3_w;
        end
    end

    // Stage 5: the blend position term is the rounded velocity times the time.
    logic signed [PB+TB:0]  r5_m2;
    logic signed [PB-1:0]   r5_vel;
    logic signed [PB-1:0]   r5_pos;
    logic [PHASE_W-1:0]     r5_phase;

    always_ff @(posedge i_clk) begin
        if (en5) begin
            r5_m2    <= r4_vel * $signed({1'b0, r4_w});
            r5_vel   <= r4_vel;
            r5_pos   <= r4_pos;
            r5_phase <= r4_phase;
        end
    end

    // Stage 6: final position, acceleration sign and the degenerate profiles.
    logic signed [WW-1:0]   adj_s6;
    logic signed [PB-1:0]   pos_s6;
    logic signed [PB-1:0]   vel_s6;
    logic signed [PB-1:0]   acc_s6;
    logic [PHASE_W-1:0]     phase_s6;
    logic [STATUS_W-1:0]    status_s6;
    logic signed [PB-1:0]   r6_pos;
    logic signed [PB-1:0]   r6_vel;
    logic signed [PB-1:0]   r6_acc;
    logic [PHASE_W-1:0]     r6_phase;
    logic [STATUS_W-1:0]    r6_status;

    always_comb begin
        adj_s6    = rnd_shift(WW'(r5_m2), TIME_FRAC + 1);
        vel_s6    = r5_vel;
        phase_s6  = r5_phase;
        status_s6 = STATUS_OK;
        case (r5_phase)
            PHASE_ACCEL: begin
                pos_s6 = sat_pos(WW'(r_start) + adj_s6);
                acc_s6 = r_acc;
            end
            PHASE_CRUISE: begin
                pos_s6 = r5_pos;
                acc_s6 = '0;
            end
            default: begin
                pos_s6 = sat_pos(WW'(r_end) - adj_s6);
                acc_s6 = sat_pos(-WW'(r_acc));
            end
        endcase
        if (r_tf == '0) begin
            // A profile with no duration reports zeros.
            pos_s6    = '0;
            vel_s6    = '0;
            acc_s6    = '0;
            phase_s6  = PHASE_ACCEL;
            status_s6 = STATUS_TIME_ZERO;
        end else if (r_start == r_end) begin
            // A profile with no travel holds the start position.
            pos_s6    = r_start;
            vel_s6    = '0;
            acc_s6    = '0;
            phase_s6  = PHASE_ACCEL;
            status_s6 = STATUS_SAME_ENDS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en6) begin
            r6_pos    <= pos_s6;
            r6_vel    <= vel_s6;
            r6_acc    <= acc_s6;
            r6_phase  <= phase_s6;
            r6_status <= status_s6;
        end
    end

    assign o_valid        = r_v6;
    assign o_position     = r6_pos;
    assign o_velocity     = r6_vel;
    assign o_acceleration = r6_acc;
    assign o_phase        = r6_phase;
    assign o_status       = r6_status;

endmodule

[hdl/lspb_div.sv]
// Restoring divider, one quotient bit per cycle, used for the derived profile values.
module lspb_div #(
    parameter int NUM_BITS = 53,
    parameter int DEN_BITS = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [NUM_BITS-1:0] i_num,
    input  logic [DEN_BITS-1:0] i_den,
    output logic                o_done,
    output logic [NUM_BITS-1:0] o_quo
);
    localparam int CNT_W = $clog2(NUM_BITS + 1);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [NUM_BITS-1:0] r_num;
    logic [DEN_BITS-1:0] r_rem;
    logic [DEN_BITS-1:0] r_den;

    logic [DEN_BITS:0]   rem_sh;
    logic [DEN_BITS:0]   rem_sub;
    logic                fits;

    // The numerator shifts out at the top while quotient bits shift in at the bottom.
    always_comb begin
        rem_sh  = {r_rem, r_num[NUM_BITS-1]};
        fits    = rem_sh >= {1'b0, r_den};
        rem_sub = fits ? (rem_sh - {1'b0, r_den}) : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_BITS-2:0], fits};
            r_rem <= rem_sub[DEN_BITS-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_num;

endmodule

[hdl/lspb_checker.sv]
// Port-level assertions for the profile sampler and their bind to the top level.
module lspb_checker #(
    parameter int POSITION_BITS = 32,
    parameter int TIME_BITS     = 24
) (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_cfg_we,
    input logic [lspb_pkg::CFG_W-1:0]       i_cfg_index,
    input logic [((POSITION_BITS > TIME_BITS) ? POSITION_BITS : TIME_BITS)-1:0] i_cfg_data,
    input logic                             i_valid,
    input logic                             o_ready,
    input logic [TIME_BITS-1:0]             i_sample_time,
    input logic                             o_valid,
    input logic                             i_ready,
    input logic signed [POSITION_BITS-1:0]  o_position,
    input logic signed [POSITION_BITS-1:0]  o_velocity,
    input logic signed [POSITION_BITS-1:0]  o_acceleration,
    input logic [lspb_pkg::PHASE_W-1:0]     o_phase,
    input logic [lspb_pkg::STATUS_W-1:0]    o_status
);
    import lspb_pkg::*;

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_position) && $stable(o_velocity)
            && $stable(o_acceleration) && $stable(o_phase) && $stable(o_status))
        else $error("result changed while stalled");

    // Degenerate profiles carry no motion.
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != STATUS_OK |->
            o_velocity == '0 && o_acceleration == '0 && o_phase == PHASE_ACCEL)
        else $error("degenerate profile reports motion");

    // Cruise has no acceleration and only occurs on a valid profile.
    a_cruise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_phase == PHASE_CRUISE |-> o_acceleration == '0 && o_status == STATUS_OK)
        else $error("cruise segment with acceleration");

    // A register write forces a rederivation before the next request.
    a_cfg_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we && (i_cfg_index == CFG_START_POSITION || i_cfg_index == CFG_END_POSITION
            || i_cfg_index == CFG_FINAL_TIME) |=> !o_ready)
        else $error("request taken before profile rederived");

endmodule

bind lspb_trajectory_sampler lspb_checker #(
    .POSITION_BITS (POSITION_BITS),
    .TIME_BITS     (TIME_BITS)
) u_lspb_checker (.*);
